// File: hw/rtl/ttb_pkg.sv
// Package for the triangle tangent basis block: payload structs and sequencer states.
// Used by triangle_tangent_basis and its checker.
`default_nettype none
package ttb_pkg;
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               degenerate;
    logic               saturated;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_OUT
  } state_t;

  localparam int DetW = 50;
  localparam int NumW = 59;
endpackage
`default_nettype wire

// File: hw/rtl/triangle_tangent_basis.sv
// Tangent/bitangent from three vertices. The first two vertices are stored as they
// arrive. After the third, multiply steps run on one shared 33x25 multiplier, then
// six bit-serial divides run on one shared divider (skipped when degenerate), then
// the output register loads and out_valid rises.
// Input stalls until the sequencer is idle again.
// Synchronous active-high reset clears corner count, sequencer and valid. Needs ttb_pkg.
`default_nettype none
module triangle_tangent_basis import ttb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_stall,
  input  vtx_t in_data,
  output logic out_valid,
  input  wire  out_stall,
  output res_t out_data
);
  localparam int DivSteps = NumW + FRAC_BITS;
  localparam int CntW = $clog2(DivSteps + 1);

  state_t state, state_next;
  logic [1:0] corner_count;
  logic signed [31:0] cpx [2], cpy [2], cpz [2];
  logic signed [23:0] cu [2], cv [2];
  logic signed [32:0] d0 [3], d1 [3];
  logic signed [24:0] du0, dv0, du1, dv1;
  logic signed [DetW-1:0] det;
  logic signed [NumW-1:0] num [6];
  logic [3:0] mstep;
  logic signed [32:0] ma;
  logic signed [24:0] mb;
  logic signed [57:0] prod;
  logic [2:0] comp;
  logic [CntW-1:0] dcnt;
  logic [NumW-1:0] nmag;
  logic [DetW-1:0] dmag;
  logic [DetW:0] rem, rem_sh;
  logic [41:0] q;
  logic neg, sat;
  logic [31:0] qres [6];
  logic accept;
  logic load_out;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  // output register is free, or its beat leaves at this edge
  assign load_out = (state == ST_OUT) && !(out_valid && out_stall);

  // multiplier schedule: det terms, then one term per numerator product
  always_comb begin
    ma = '0; mb = '0;
    unique case (mstep)
      4'd0: begin ma = 33'(du0); mb = dv1; end
      4'd1: begin ma = 33'(dv0); mb = du1; end
      4'd2, 4'd3, 4'd4: begin ma = d0[2'(mstep - 4'd2)]; mb = dv1; end
      4'd5, 4'd6, 4'd7: begin ma = d1[2'(mstep - 4'd5)]; mb = dv0; end
      4'd8, 4'd9, 4'd10: begin ma = d1[2'(mstep - 4'd8)]; mb = du0; end
      4'd11, 4'd12, 4'd13: begin ma = d0[2'(mstep - 4'd11)]; mb = du1; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = ma * mb;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && corner_count == 2'd2) state_next = ST_MUL;
      ST_MUL:  if (mstep == 4'd13) state_next = (det == '0) ? ST_OUT : ST_DIV;
      ST_DIV:  if (dcnt == CntW'(DivSteps) && comp == 3'd5) state_next = ST_OUT;
      ST_OUT:  if (!(out_valid && out_stall)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // numerator magnitude shifts out MSB first; zeros follow for the fraction bits
  assign rem_sh = {rem[DetW-1:0], nmag[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; corner_count <= '0; out_valid <= 1'b0;
      mstep <= '0; comp <= '0; dcnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (corner_count != 2'd2) begin
          cpx[corner_count[0]] <= in_data.pos_x; cpy[corner_count[0]] <= in_data.pos_y;
          cpz[corner_count[0]] <= in_data.pos_z; cu[corner_count[0]] <= in_data.tex_u;
          cv[corner_count[0]] <= in_data.tex_v;
          corner_count <= corner_count + 2'd1;
        end else begin
          corner_count <= '0;
          d0[0] <= 33'(cpx[1]) - 33'(cpx[0]); d1[0] <= 33'(in_data.pos_x) - 33'(cpx[0]);
          d0[1] <= 33'(cpy[1]) - 33'(cpy[0]); d1[1] <= 33'(in_data.pos_y) - 33'(cpy[0]);
          d0[2] <= 33'(cpz[1]) - 33'(cpz[0]); d1[2] <= 33'(in_data.pos_z) - 33'(cpz[0]);
          du0 <= 25'(cu[1]) - 25'(cu[0]); dv0 <= 25'(cv[1]) - 25'(cv[0]);
          du1 <= 25'(in_data.tex_u) - 25'(cu[0]); dv1 <= 25'(in_data.tex_v) - 25'(cv[0]);
          mstep <= '0;
        end
      end
      if (state == ST_MUL) begin
        mstep <= mstep + 4'd1;
        unique case (mstep)
          4'd0: det <= DetW'(prod);
          4'd1: det <= det - DetW'(prod);
          4'd2, 4'd3, 4'd4: num[3'(mstep - 4'd2)] <= NumW'(prod);
          4'd5, 4'd6, 4'd7:
            num[3'(mstep - 4'd5)] <= num[3'(mstep - 4'd5)] - NumW'(prod);
          4'd8, 4'd9, 4'd10: num[3'(mstep - 4'd5)] <= NumW'(prod);
          4'd11, 4'd12, 4'd13:
            num[3'(mstep - 4'd8)] <= num[3'(mstep - 4'd8)] - NumW'(prod);
          default: ;
        endcase
        if (mstep == 4'd13) begin
          comp <= '0; dcnt <= '0; sat <= 1'b0;
          dmag <= det[DetW-1] ? DetW'(-det) : DetW'(det);
        end
      end
      if (state == ST_DIV) begin
        if (dcnt == '0) begin
          nmag <= num[comp][NumW-1] ? NumW'(-num[comp]) : NumW'(num[comp]);
          neg  <= num[comp][NumW-1] ^ det[DetW-1];
          rem <= '0; q <= '0;
          dcnt <= dcnt + CntW'(1);
        end else begin
          // quotient stops growing once it is far beyond 32 bits
          if (rem_sh >= {1'b0, dmag}) begin
            rem <= rem_sh - {1'b0, dmag};
            if (q[41:40] == 2'b00) q <= {q[40:0], 1'b1};
          end else begin
            rem <= rem_sh;
            if (q[41:40] == 2'b00) q <= {q[40:0], 1'b0};
          end
          nmag <= {nmag[NumW-2:0], 1'b0};
          if (dcnt == CntW'(DivSteps)) begin
            dcnt <= '0; comp <= comp + 3'd1;
          end else begin
            dcnt <= dcnt + CntW'(1);
          end
        end
      end
      if (state == ST_DIV && dcnt == '0 && comp != '0) begin
        // finish previous component
        if (neg) begin
          if (q > 42'h80000000) begin sat <= 1'b1; qres[comp-3'd1] <= 32'h80000000; end
          else qres[comp-3'd1] <= 32'(-q);
        end else if (q > 42'h7FFFFFFF) begin
          sat <= 1'b1; qres[comp-3'd1] <= 32'h7FFFFFFF;
        end else qres[comp-3'd1] <= q[31:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
        if (det == '0) out_data <= '{default: '0, degenerate: 1'b1};
        else begin
          out_data.tangent_x <= qres[0]; out_data.tangent_y <= qres[1];
          out_data.tangent_z <= qres[2]; out_data.bitangent_x <= qres[3];
          out_data.bitangent_y <= qres[4];
          out_data.degenerate <= 1'b0;
          if (neg) begin
            out_data.bitangent_z <= (q > 42'h80000000) ? 32'h80000000 : 32'(-q);
            out_data.saturated <= sat || (q > 42'h80000000);
          end else begin
            out_data.bitangent_z <= (q > 42'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            out_data.saturated <= sat || (q > 42'h7FFFFFFF);
          end
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/ttb_checker.sv
// Port-level checker for triangle_tangent_basis, bound into every instance of it.
// Depends on ttb_pkg.
`default_nettype none
module ttb_checker import ttb_pkg::*; (
  input wire  clk,
  input wire  rst,
  input wire  in_stall,
  input wire  out_valid,
  input wire  out_stall,
  input res_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out beat dropped");
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("valid after reset");
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall)) else $error("result without busy sequencer");
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> !out_data.saturated && out_data.tangent_x == 0)
    else $error("degenerate result not zero");
endmodule

bind triangle_tangent_basis ttb_checker u_chk (.*);
`default_nettype wire
